/* hdl/hsl_pkg.sv */
// Shared constants, types and the arctangent table of the heading slew limiter.
`timescale 1ns / 1ps

package hsl_pkg;

    // Default coordinate width and fixed field widths.
    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS     = 16;
    localparam int RATE_BITS      = 20;
    localparam int TIME_BITS      = 16;
    localparam int OUT_TDATA_BITS = 24;

    localparam logic [RATE_BITS-1:0] TURN_RATE_RESET = RATE_BITS'(32768);

    // CORDIC setup: vectors are scaled by 2^24, the angle is kept in 2^32 per turn.
    localparam int CORDIC_ITERS = 30;
    localparam int ITER_BITS    = $clog2(CORDIC_ITERS);
    localparam int CORDIC_SHIFT = 24;
    localparam int CORDIC_GUARD = 4;
    localparam int ACC_BITS     = 32;

    localparam logic [ACC_BITS-1:0] ACC_HALF_TURN = ACC_BITS'(64'd1 << (ACC_BITS - 1));
    localparam logic [ACC_BITS-1:0] ACC_ROUND     =
        ACC_BITS'(64'd1 << (ACC_BITS - 1 - ANGLE_BITS));

    localparam int HALF_TURN = 2 ** (ANGLE_BITS - 1);
    localparam int ONE_DEG   = (2 ** ANGLE_BITS + 180) / 360;

    typedef enum logic {
        OP_SET_TARGET = 1'b0,
        OP_TICK       = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REASON_NONE      = 2'd0,
        REASON_REACHED   = 2'd1,
        REASON_TOO_CLOSE = 2'd2,
        REASON_BAD_LOOK  = 2'd3
    } end_reason_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 check;
        logic                 step;
        logic [ITER_BITS-1:0] iter;
        logic                 round;
        logic                 finish;
        logic                 push;
    } hsl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run;
    } hsl_status_t;

    // atan(2^-i) in units of 2^32 per turn.
    function automatic logic [ACC_BITS-1:0] cordic_atan(input logic [ITER_BITS-1:0] i);
        logic [ACC_BITS-1:0] a;
        unique case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/hsl_cordic.sv */
// One CORDIC vectoring lane that turns an (x, z) vector into its binary angle.
`timescale 1ns / 1ps

module hsl_cordic #(
    parameter int COORD_BITS = hsl_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              init,
    input  logic                              step,
    input  logic [hsl_pkg::ITER_BITS-1:0]     iter,
    input  logic signed [COORD_BITS:0]        x_in,
    input  logic signed [COORD_BITS:0]        z_in,
    output logic [hsl_pkg::ACC_BITS-1:0]      acc_out
);

    localparam int W = COORD_BITS + 1 + hsl_pkg::CORDIC_SHIFT + hsl_pkg::CORDIC_GUARD;

    logic signed [W-1:0]              cx_reg, cy_reg;
    logic signed [W-1:0]              cx_next, cy_next;
    logic [hsl_pkg::ACC_BITS-1:0]     acc_reg, acc_next;
    logic signed [W-1:0]              xs, zs, sx, sy;

    assign xs = W'(x_in) <<< hsl_pkg::CORDIC_SHIFT;
    assign zs = W'(z_in) <<< hsl_pkg::CORDIC_SHIFT;
    assign sx = cx_reg >>> iter;
    assign sy = cy_reg >>> iter;

    // Rotate toward the z axis; the sign of y picks the direction.
    always_comb begin
        if (!cy_reg[W-1]) begin
            cx_next  = cx_reg + sy;
            cy_next  = cy_reg - sx;
            acc_next = acc_reg + hsl_pkg::cordic_atan(iter);
        end else begin
            cx_next  = cx_reg - sy;
            cy_next  = cy_reg + sx;
            acc_next = acc_reg - hsl_pkg::cordic_atan(iter);
        end
    end

    // A vector in the back half plane is flipped first and starts at a half turn.
    always_ff @(posedge aclk) begin
        if (init) begin
            if (z_in[COORD_BITS]) begin
                cx_reg  <= -zs;
                cy_reg  <= -xs;
                acc_reg <= hsl_pkg::ACC_HALF_TURN;
            end else begin
                cx_reg  <= zs;
                cy_reg  <= xs;
                acc_reg <= '0;
            end
        end else if (step) begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

/* hdl/hsl_datapath.sv */
// Datapath of the heading slew limiter: goal and input registers, yaw lanes and result.
`timescale 1ns / 1ps

module hsl_datapath #(
    parameter int COORD_BITS = hsl_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [hsl_pkg::RATE_BITS-1:0]          cfg_wdata,
    input  logic [((6*COORD_BITS+hsl_pkg::TIME_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                   s_tuser,
    input  hsl_pkg::hsl_cmd_t                      cmd,
    output hsl_pkg::hsl_status_t                   sts,
    output logic [hsl_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
    output logic                                   m_tuser
);

    localparam int A  = hsl_pkg::ANGLE_BITS;
    localparam int C  = COORD_BITS;
    localparam int PW = hsl_pkg::RATE_BITS + hsl_pkg::TIME_BITS;

    localparam logic signed [C:0] NZ_LIM = (C+1)'(2);
    localparam logic [hsl_pkg::RATE_BITS-1:0] HALF_STEP =
        hsl_pkg::RATE_BITS'(hsl_pkg::HALF_TURN);
    localparam logic [A:0] ONE_DEG_W = (A+1)'(hsl_pkg::ONE_DEG);

    // Near zero length: squared length of at most 6, so both parts within
    // two and not both of magnitude two.
    function automatic logic near_zero(input logic signed [C:0] a,
                                       input logic signed [C:0] b);
        logic a_in, b_in, a_two, b_two;
        a_in  = (a >= -NZ_LIM) && (a <= NZ_LIM);
        b_in  = (b >= -NZ_LIM) && (b <= NZ_LIM);
        a_two = (a == NZ_LIM) || (a == -NZ_LIM);
        b_two = (b == NZ_LIM) || (b == -NZ_LIM);
        return a_in && b_in && !(a_two && b_two);
    endfunction

    // Configuration and persistent state.
    logic [hsl_pkg::RATE_BITS-1:0] turn_rate_reg;
    logic                          armed_reg;
    logic [C-1:0]                  goal_x_reg, goal_z_reg;

    // Captured input word.
    hsl_pkg::opcode_t              op_reg;
    logic [C-1:0]                  pos_x_reg, pos_z_reg, look_x_reg, look_z_reg;
    logic [hsl_pkg::TIME_BITS-1:0] ts_reg;

    // Working and result registers.
    logic [PW-1:0]                 prod_reg;
    logic [A-1:0]                  step_reg, cur_yaw_reg, tgt_yaw_reg;
    logic                          res_valid_reg, res_turn_reg;
    logic [A-1:0]                  res_yaw_reg;
    hsl_pkg::end_reason_t          res_reason_reg;
    logic [hsl_pkg::OUT_TDATA_BITS-1:0] m_tdata_reg;
    logic                          m_tuser_reg;

    logic signed [C:0]             dx, dz, lx, lz;
    logic                          too_close, bad_look;
    logic [hsl_pkg::ACC_BITS-1:0]  acc_cur, acc_tgt, rnd_cur, rnd_tgt;
    logic [hsl_pkg::RATE_BITS-1:0] step_raw;
    logic [A-1:0]                  delta;
    logic [A:0]                    mag;
    logic                          snap;
    logic [A-1:0]                  yaw_step;

    assign dx = {goal_x_reg[C-1], goal_x_reg} - {pos_x_reg[C-1], pos_x_reg};
    assign dz = {goal_z_reg[C-1], goal_z_reg} - {pos_z_reg[C-1], pos_z_reg};
    assign lx = {look_x_reg[C-1], look_x_reg};
    assign lz = {look_z_reg[C-1], look_z_reg};

    assign too_close = near_zero(dx, dz);
    assign bad_look  = near_zero(lx, lz);
    assign sts.run   = (op_reg == hsl_pkg::OP_TICK) && armed_reg && !too_close && !bad_look;

    hsl_cordic #(.COORD_BITS(COORD_BITS)) u_cordic_cur (
        .aclk    (aclk),
        .init    (cmd.check),
        .step    (cmd.step),
        .iter    (cmd.iter),
        .x_in    (lx),
        .z_in    (lz),
        .acc_out (acc_cur)
    );

    hsl_cordic #(.COORD_BITS(COORD_BITS)) u_cordic_tgt (
        .aclk    (aclk),
        .init    (cmd.check),
        .step    (cmd.step),
        .iter    (cmd.iter),
        .x_in    (dx),
        .z_in    (dz),
        .acc_out (acc_tgt)
    );

    // Round half up from 2^32 per turn to the binary angle width.
    assign rnd_cur  = acc_cur + hsl_pkg::ACC_ROUND;
    assign rnd_tgt  = acc_tgt + hsl_pkg::ACC_ROUND;
    assign step_raw = prod_reg[PW-1:hsl_pkg::TIME_BITS];

    // Signed angle difference, its magnitude and the limited step.
    assign delta    = tgt_yaw_reg - cur_yaw_reg;
    assign mag      = delta[A-1] ? ((A+1)'(0) - {delta[A-1], delta}) : {1'b0, delta};
    assign snap     = (mag <= {1'b0, step_reg}) || (mag <= ONE_DEG_W);
    assign yaw_step = delta[A-1] ? (cur_yaw_reg - step_reg) : (cur_yaw_reg + step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_rate_reg <= hsl_pkg::TURN_RATE_RESET;
            armed_reg     <= 1'b0;
            goal_x_reg    <= '0;
            goal_z_reg    <= '0;
        end else begin
            if (cfg_we) begin
                turn_rate_reg <= cfg_wdata;
            end
            if (cmd.load && (hsl_pkg::opcode_t'(s_tuser) == hsl_pkg::OP_SET_TARGET)) begin
                goal_x_reg <= s_tdata[C-1:0];
                goal_z_reg <= s_tdata[2*C-1:C];
                armed_reg  <= 1'b1;
            end else if (cmd.check && (op_reg == hsl_pkg::OP_TICK) && armed_reg &&
                         (too_close || bad_look)) begin
                armed_reg <= 1'b0;
            end else if (cmd.finish && snap) begin
                armed_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= hsl_pkg::opcode_t'(s_tuser);
            pos_x_reg  <= s_tdata[3*C-1:2*C];
            pos_z_reg  <= s_tdata[4*C-1:3*C];
            look_x_reg <= s_tdata[5*C-1:4*C];
            look_z_reg <= s_tdata[6*C-1:5*C];
            ts_reg     <= s_tdata[6*C+hsl_pkg::TIME_BITS-1:6*C];
        end

        if (cmd.check) begin
            prod_reg <= PW'(turn_rate_reg) * PW'(ts_reg);
            res_valid_reg <= 1'b0;
            res_yaw_reg   <= '0;
            if (op_reg == hsl_pkg::OP_SET_TARGET) begin
                res_turn_reg   <= 1'b1;
                res_reason_reg <= hsl_pkg::REASON_NONE;
            end else if (!armed_reg) begin
                res_turn_reg   <= 1'b0;
                res_reason_reg <= hsl_pkg::REASON_NONE;
            end else if (too_close) begin
                res_turn_reg   <= 1'b0;
                res_reason_reg <= hsl_pkg::REASON_TOO_CLOSE;
            end else if (bad_look) begin
                res_turn_reg   <= 1'b0;
                res_reason_reg <= hsl_pkg::REASON_BAD_LOOK;
            end else begin
                res_turn_reg   <= 1'b1;
                res_reason_reg <= hsl_pkg::REASON_NONE;
            end
        end

        if (cmd.round) begin
            cur_yaw_reg <= rnd_cur[hsl_pkg::ACC_BITS-1:hsl_pkg::ACC_BITS-A];
            tgt_yaw_reg <= rnd_tgt[hsl_pkg::ACC_BITS-1:hsl_pkg::ACC_BITS-A];
            step_reg    <= (step_raw > HALF_STEP) ? A'(HALF_STEP) : A'(step_raw);
        end

        if (cmd.finish) begin
            res_valid_reg <= 1'b1;
            if (snap) begin
                res_yaw_reg    <= tgt_yaw_reg;
                res_turn_reg   <= 1'b0;
                res_reason_reg <= hsl_pkg::REASON_REACHED;
            end else begin
                res_yaw_reg    <= yaw_step;
                res_turn_reg   <= 1'b1;
                res_reason_reg <= hsl_pkg::REASON_NONE;
            end
        end

        if (cmd.push) begin
            m_tdata_reg <= hsl_pkg::OUT_TDATA_BITS'({res_reason_reg, res_turn_reg, res_yaw_reg});
            m_tuser_reg <= res_valid_reg;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

/* hdl/hsl_ctrl.sv */
// Controller state machine of the heading slew limiter.
`timescale 1ns / 1ps

module hsl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  hsl_pkg::hsl_status_t  sts,
    output hsl_pkg::hsl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ITER,
        ST_ROUND,
        ST_FINISH,
        ST_DONE
    } state_t;

    localparam logic [hsl_pkg::ITER_BITS-1:0] ITER_LAST =
        hsl_pkg::ITER_BITS'(hsl_pkg::CORDIC_ITERS - 1);

    state_t                          state_reg;
    logic [hsl_pkg::ITER_BITS-1:0]   iter_reg;
    logic                            m_tvalid_reg;
    logic                            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !cmd.push) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    iter_reg <= '0;
                    if (sts.run) begin
                        state_reg <= ST_ITER;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_ITER: begin
                    if (iter_reg == ITER_LAST) begin
                        state_reg <= ST_ROUND;
                    end else begin
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                ST_ROUND: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;

    assign cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.check  = (state_reg == ST_CHECK);
    assign cmd.step   = (state_reg == ST_ITER);
    assign cmd.iter   = iter_reg;
    assign cmd.round  = (state_reg == ST_ROUND);
    assign cmd.finish = (state_reg == ST_FINISH);
    assign cmd.push   = (state_reg == ST_DONE) && out_free;

endmodule

/* hdl/heading_slew_limiter_core.sv */
// Top level of the heading slew limiter: controller, datapath and stream ports.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// cfg       in         cfg_we              cfg_wdata: turn_rate (20 bits)
// s_        in         s_tvalid/s_tready   s_tuser: opcode; s_tdata: target, pos, look, time
// m_        out        m_tvalid/m_tready   m_tuser: yaw_valid; m_tdata: yaw, turning, reason
//
// m_tvalid rises after the CHECK and DONE states when a set-target word or a tick that
// does not turn is taken, and after CHECK, the 30 iterations of the two CORDIC lanes that
// resolve the look and target yaws side by side, ROUND, FINISH and DONE for a tick while
// turning. s_tready rises with it. Reset (aresetn low at a clock edge) disarms turning,
// clears the goal and loads the turn rate with 32768. The output register holds its word
// while m_tready is low; the next word is taken and its result waits for it.

module heading_slew_limiter_core #(
    parameter int COORD_BITS = hsl_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    // Turn rate register, binary-angle units per second.
    input  logic                                   cfg_we,
    input  logic [hsl_pkg::RATE_BITS-1:0]          cfg_wdata,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Low bit up: target_x, target_z, pos_x, pos_z, look_x, look_z (COORD_BITS each),
    // time_step (16 bits), zero fill to whole bytes.
    input  logic [((6*COORD_BITS+hsl_pkg::TIME_BITS+7)/8)*8-1:0] s_tdata,
    // opcode: 0 sets the target and arms turning, 1 is a time tick.
    input  logic                                   s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Low bit up: new_yaw (16 bits, signed), turning (1 bit), end_reason (2 bits),
    // zero fill to 24 bits.
    output logic [hsl_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
    // yaw_valid: the word carries a yaw to apply.
    output logic                                   m_tuser
);

    hsl_pkg::hsl_cmd_t    cmd;
    hsl_pkg::hsl_status_t sts;

    // The controller sequences check, CORDIC iterations, rounding, the final
    // step decision and the hand-off to the output register.
    hsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the goal, the armed flag, the turn rate, both CORDIC
    // lanes and the output register.
    hsl_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
